/* rtl/core/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list engine: command and status
// codes, the control word broadcast to every cell, and the search carry.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int POS_W        = 8;
	localparam int DATA_W       = 32;
	localparam int STAT_W       = 2;
	localparam int CMD_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_PUSH_H = 3'd1,
		CMD_PUSH_T = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4,
		CMD_GET    = 3'd5,
		CMD_FIND   = 3'd6
	} cmd_t;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		M_HOLD  = 2'd0,
		M_OPEN  = 2'd1,
		M_CLOSE = 2'd2,
		M_PROBE = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t        mode;
		logic              find;
		logic [POS_W-1:0]  slot;
		logic [POS_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} carry_t;

endpackage

/* rtl/core/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed words held in a chain of cells: clear, push,
// insert and delete by position, get by position, find first match.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    command, position, value
// rsp       out  rsp_valid/rsp_ready    status, read_value, found_position, length
//
// Clear, push, insert, delete, unknown codes and a get with a bad position
// finish at the accept edge; the response is valid in the next cycle.
// Get and find respond after a search: the accept edge flags matches, the scan
// state ripples the first match down the chain of carry registers, and its
// last edge loads the response; the next request waits until the scan ends.
// A new request is taken only with no search running and the response
// register empty or draining. Reset clears the element count; the length output and cell data are not reset.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [pls_pkg::CMD_W-1:0]         command,
	input  logic [pls_pkg::POS_W-1:0]         position,
	input  logic signed [pls_pkg::DATA_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [pls_pkg::STAT_W-1:0]        status,
	output logic signed [pls_pkg::DATA_W-1:0] read_value,
	output logic [pls_pkg::POS_W-1:0]         found_position,
	output logic [pls_pkg::POS_W-1:0]         length
);
	import pls_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      count_q;
	logic               find_q;
	logic               rsp_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [DATA_W-1:0]  read_value_q;
	logic [POS_W-1:0]   found_position_q;
	logic [POS_W-1:0]   length_q;

	logic               req_fire;
	logic               full;
	logic [POS_W:0]     pos9;
	logic [POS_W:0]     cnt9;
	logic               pos_ok_ins;
	logic               pos_ok_rd;
	logic [POS_W-1:0]   slot_pos;
	cell_ctl_t          ctl;
	logic [CW-1:0]      count_d;
	logic [STAT_W-1:0]  status_d;
	logic               scan_go;
	logic               scan_done;
	carry_t             last_carry;

	logic [DATA_W-1:0]  data_w  [CAPACITY];
	logic [DATA_W-1:0]  left_w  [CAPACITY];
	logic [DATA_W-1:0]  right_w [CAPACITY];
	carry_t             cin_w   [CAPACITY];
	carry_t             carry_w [CAPACITY];

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign pos9      = {1'b0, position};
	assign cnt9      = (POS_W+1)'(count_q);
	assign pos_ok_ins = (position != '0) && (pos9 <= cnt9 + (POS_W+1)'(1));
	assign pos_ok_rd  = (position != '0) && (pos9 <= cnt9);
	assign slot_pos   = position - POS_W'(1);
	assign scan_done  = (state_q == S_SCAN) && (cnt_q == CW'(CAPACITY));
	assign last_carry = carry_w[CAPACITY-1];

	always_comb begin
		ctl.mode  = M_HOLD;
		ctl.find  = 1'b0;
		ctl.slot  = '0;
		ctl.count = POS_W'(count_q);
		ctl.value = value;
		count_d   = count_q;
		status_d  = ST_OK;
		scan_go   = 1'b0;
		if (req_fire) begin
			unique case (cmd_t'(command))
				CMD_CLEAR: begin
					count_d = '0;
				end
				CMD_PUSH_H: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctl.mode = M_OPEN;
						count_d  = count_q + CW'(1);
					end
				end
				CMD_PUSH_T: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctl.mode = M_OPEN;
						ctl.slot = POS_W'(count_q);
						count_d  = count_q + CW'(1);
					end
				end
				CMD_INSERT: begin
					if (!pos_ok_ins) begin
						status_d = ST_BADPOS;
					end else if (full) begin
						status_d = ST_FULL;
					end else begin
						ctl.mode = M_OPEN;
						ctl.slot = slot_pos;
						count_d  = count_q + CW'(1);
					end
				end
				CMD_DELETE: begin
					if (!pos_ok_rd) begin
						status_d = ST_BADPOS;
					end else begin
						ctl.mode = M_CLOSE;
						ctl.slot = slot_pos;
						count_d  = count_q - CW'(1);
					end
				end
				CMD_GET: begin
					if (!pos_ok_rd) begin
						status_d = ST_BADPOS;
					end else begin
						ctl.mode = M_PROBE;
						ctl.slot = slot_pos;
						scan_go  = 1'b1;
					end
				end
				CMD_FIND: begin
					ctl.mode = M_PROBE;
					ctl.find = 1'b1;
					scan_go  = 1'b1;
				end
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_w[i] = '0;
			assign cin_w[i]  = '0;
		end else begin : g_body
			assign left_w[i] = data_w[i-1];
			assign cin_w[i]  = carry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w[i] = data_w[i];
		end else begin : g_mid
			assign right_w[i] = data_w[i+1];
		end

		pls_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_data (left_w[i]),
			.right_data(right_w[i]),
			.carry_in  (cin_w[i]),
			.data      (data_w[i]),
			.carry_out (carry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			find_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			unique case (state_q)
				S_IDLE: begin
					if (scan_go) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						find_q  <= ctl.find;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (scan_done) begin
						state_q <= S_IDLE;
					end
				end
			endcase
			if ((req_fire && !scan_go) || scan_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && !scan_go) begin
			status_q         <= status_d;
			read_value_q     <= '0;
			found_position_q <= '0;
			length_q         <= POS_W'(count_d);
		end else if (scan_done) begin
			length_q <= POS_W'(count_q);
			if (find_q) begin
				status_q         <= last_carry.hit ? ST_OK : ST_NOTFOUND;
				read_value_q     <= '0;
				found_position_q <= last_carry.hit ? last_carry.pos : '0;
			end else begin
				status_q         <= ST_OK;
				read_value_q     <= last_carry.data;
				found_position_q <= '0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found_position = found_position_q;
	assign length         = length_q;

`ifndef SYNTH
	a_req_leads_on: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid || state_q == S_SCAN)
		else $error("request neither answered nor searching");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !rsp_valid && !req_ready)
		else $error("handshake active during search");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found_position != '0 |-> status == ST_OK && read_value == '0)
		else $error("found position with bad status or data");
`endif

endmodule

/* rtl/core/pls_cell.sv */
// ----------------------------------------------------------------------------
// pls_cell
// One list slot. Shifts with its neighbors on insert and delete, flags a
// match on a probe, and passes the first match down the chain.
// ----------------------------------------------------------------------------
module pls_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pls_pkg::cell_ctl_t        ctl,
	input  logic [pls_pkg::DATA_W-1:0] left_data,
	input  logic [pls_pkg::DATA_W-1:0] right_data,
	input  pls_pkg::carry_t           carry_in,
	output logic [pls_pkg::DATA_W-1:0] data,
	output pls_pkg::carry_t           carry_out
);
	import pls_pkg::*;

	localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);
	localparam logic [POS_W-1:0] POS_P = POS_W'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic              hit_q;
	carry_t            carry_q;

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			M_OPEN: begin
				if (IDX_P > ctl.slot) begin
					data_q <= left_data;
				end else if (IDX_P == ctl.slot) begin
					data_q <= ctl.value;
				end
			end
			M_CLOSE: begin
				if (IDX_P >= ctl.slot) begin
					data_q <= right_data;
				end
			end
			M_PROBE: ;
			M_HOLD: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			carry_q <= '0;
		end else begin
			if (ctl.mode == M_PROBE) begin
				hit_q <= (IDX_P < ctl.count) &&
				         (ctl.find ? (data_q == ctl.value) : (IDX_P == ctl.slot));
			end
			// earlier cells win: keep an upstream hit, else offer our own
			if (carry_in.hit) begin
				carry_q <= carry_in;
			end else begin
				carry_q <= '{hit: hit_q, data: data_q, pos: POS_P};
			end
		end
	end

	assign data      = data_q;
	assign carry_out = carry_q;

endmodule
